>>> hw/rtl/sha1_pkg.sv
`default_nettype none

package sha1_pkg;

  localparam int unsigned CountW     = 61;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned BlockBits  = BlockBytes * 8;
  localparam int unsigned Rounds     = 80;
  localparam int unsigned PosW       = $clog2(BlockBytes);

  // Five 32-bit words: the working variables of a round, or the chaining words.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha1_work_t;

  localparam sha1_work_t HashInit = '{
    a: 32'h67452301,
    b: 32'hEFCDAB89,
    c: 32'h98BADCFE,
    d: 32'h10325476,
    e: 32'hC3D2E1F0
  };

  localparam logic [31:0] RoundK0 = 32'h5A827999;
  localparam logic [31:0] RoundK1 = 32'h6ED9EBA1;
  localparam logic [31:0] RoundK2 = 32'h8F1BBCDC;
  localparam logic [31:0] RoundK3 = 32'hCA62C1D6;

  localparam logic [7:0]      PadByte  = 8'h80;
  localparam logic [PosW-1:0] LenStart = PosW'(BlockBytes - 8);

endpackage

`default_nettype wire

>>> hw/rtl/sha1_in_if.sv
`default_nettype none

interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sha1_out_if.sv
`default_nettype none

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sha1_hash_engine.sv
`default_nettype none

// Channel  Dir  Fields                                 Handshake
// in_i     in   op[0], data_byte[7:0]                  valid/ready
// out_o    out  digest_word[31:0], word_index[2:0],    valid/ready
//               last_word
//
// An appended byte goes into the 64-byte block RAM.
// The byte that fills a block starts a compression: the block is streamed
// out of the RAM into the schedule register, then 80 rounds, then one add.
// A finish takes one or two such compressions (two when 56 or more bytes are
// pending), then the five digest words, one per cycle while out_o is ready.
// Input is taken only while no compression or digest is in progress.
// Reset loads the initial chaining words and clears the byte count; the RAM
// is not cleared, since no byte is read before it is written.

module sha1_hash_engine (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  sha1_in_if.sink     in_i,
  sha1_out_if.source  out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_e;

  // Which block the load phase builds.
  typedef enum logic [1:0] {
    BLK_DATA,
    BLK_PAD,
    BLK_LEN
  } blk_kind_e;

  state_e                         state_q, state_d;
  blk_kind_e                      kind_q, kind_d;
  logic [6:0]                     cnt_q, cnt_d;
  logic [6:0]                     rnd_q, rnd_d;
  logic [2:0]                     widx_q, widx_d;
  logic [sha1_pkg::BlockBits-1:0] sched_q, sched_d;
  sha1_pkg::sha1_work_t           work_q, work_d;
  sha1_pkg::sha1_work_t           hash_q, hash_d;
  logic [sha1_pkg::CountW-1:0]    count_q, count_d;

  logic                      in_fire;
  logic                      out_fire;
  logic                      ram_we;
  logic                      ram_re;
  logic [sha1_pkg::PosW-1:0] pos;
  logic [7:0]                ram_rdata;
  logic [6:0]                cnt_m1;
  logic [sha1_pkg::PosW-1:0] idx;
  logic [63:0]               len_bits;
  logic [2:0]                len_sel;
  logic [7:0]                len_byte;
  logic [7:0]                load_byte;
  logic [31:0]               sched_x;
  logic [31:0]               sched_new;
  sha1_pkg::sha1_work_t      work_next;

  assign pos      = count_q[sha1_pkg::PosW-1:0];
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  assign ram_we = in_fire && !in_i.op;
  assign ram_re = (state_q == ST_LOAD) && (cnt_q < 7'(sha1_pkg::BlockBytes));

  sha1_ram #(
    .Width (8),
    .Depth (sha1_pkg::BlockBytes)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos),
    .wdata_i (in_i.data_byte),
    .re_i    (ram_re),
    .raddr_i (cnt_q[sha1_pkg::PosW-1:0]),
    .rdata_o (ram_rdata)
  );

  // The RAM read is registered, so the byte arriving now belongs to cnt - 1.
  assign cnt_m1   = cnt_q - 7'd1;
  assign idx      = cnt_m1[sha1_pkg::PosW-1:0];
  assign len_bits = {count_q, 3'b000};
  assign len_sel  = 3'd7 - idx[2:0];
  assign len_byte = len_bits[{len_sel, 3'b000} +: 8];

  always_comb begin
    load_byte = ram_rdata;
    case (kind_q)
      BLK_PAD: begin
        if (idx == pos) begin
          load_byte = sha1_pkg::PadByte;
        end else if (idx > pos) begin
          // The length fits behind the pad byte only when it landed below 56.
          if (pos < sha1_pkg::LenStart && idx >= sha1_pkg::LenStart) begin
            load_byte = len_byte;
          end else begin
            load_byte = 8'h00;
          end
        end
      end
      BLK_LEN: begin
        load_byte = (idx >= sha1_pkg::LenStart) ? len_byte : 8'h00;
      end
      default: begin
        load_byte = ram_rdata;
      end
    endcase
  end

  // Word t sits at the top of the schedule register; w[t+16] is built from
  // w[t+13], w[t+8], w[t+2] and w[t].
  assign sched_x   = sched_q[511:480] ^ sched_q[447:416] ^ sched_q[255:224] ^ sched_q[95:64];
  assign sched_new = {sched_x[30:0], sched_x[31]};

  sha1_round u_round (
    .work_i       (work_q),
    .sched_word_i (sched_q[511:480]),
    .round_i      (rnd_q),
    .work_o       (work_next)
  );

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cnt_d   = cnt_q;
    rnd_d   = rnd_q;
    widx_d  = widx_q;
    sched_d = sched_q;
    work_d  = work_q;
    hash_d  = hash_q;
    count_d = count_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_d = '0;
          if (!in_i.op) begin
            count_d = count_q + sha1_pkg::CountW'(1);
            if (pos == sha1_pkg::PosW'(sha1_pkg::BlockBytes - 1)) begin
              kind_d  = BLK_DATA;
              state_d = ST_LOAD;
            end
          end else begin
            kind_d  = BLK_PAD;
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q != 7'd0) begin
          sched_d = {sched_q[sha1_pkg::BlockBits-9:0], load_byte};
        end
        if (cnt_q == 7'(sha1_pkg::BlockBytes)) begin
          work_d  = hash_q;
          rnd_d   = '0;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        work_d  = work_next;
        sched_d = {sched_q[sha1_pkg::BlockBits-33:0], sched_new};
        rnd_d   = rnd_q + 7'd1;
        if (rnd_q == 7'(sha1_pkg::Rounds - 1)) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        hash_d.a = hash_q.a + work_q.a;
        hash_d.b = hash_q.b + work_q.b;
        hash_d.c = hash_q.c + work_q.c;
        hash_d.d = hash_q.d + work_q.d;
        hash_d.e = hash_q.e + work_q.e;
        cnt_d    = '0;
        widx_d   = '0;
        unique case (kind_q)
          BLK_PAD: begin
            if (pos >= sha1_pkg::LenStart) begin
              kind_d  = BLK_LEN;
              state_d = ST_LOAD;
            end else begin
              state_d = ST_EMIT;
            end
          end
          BLK_LEN: state_d = ST_EMIT;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_EMIT: begin
        if (out_fire) begin
          widx_d = widx_q + 3'd1;
          if (widx_q == 3'd4) begin
            hash_d  = sha1_pkg::HashInit;
            count_d = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= BLK_DATA;
      cnt_q   <= '0;
      rnd_q   <= '0;
      widx_q  <= '0;
      hash_q  <= sha1_pkg::HashInit;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      cnt_q   <= cnt_d;
      rnd_q   <= rnd_d;
      widx_q  <= widx_d;
      hash_q  <= hash_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sched_q <= sched_d;
    work_q  <= work_d;
  end

  assign in_i.ready = (state_q == ST_IDLE);

  assign out_o.valid      = (state_q == ST_EMIT);
  assign out_o.word_index = widx_q;
  assign out_o.last_word  = (widx_q == 3'd4);

  always_comb begin
    case (widx_q)
      3'd0:    out_o.digest_word = hash_q.a;
      3'd1:    out_o.digest_word = hash_q.b;
      3'd2:    out_o.digest_word = hash_q.c;
      3'd3:    out_o.digest_word = hash_q.d;
      default: out_o.digest_word = hash_q.e;
    endcase
  end

  a_no_input_during_digest: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid
  ) else $error("input accepted while digest words are pending");

  a_full_block_stalls: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_i.op && pos == sha1_pkg::PosW'(sha1_pkg::BlockBytes - 1))
      |=> !in_i.ready
  ) else $error("input still taken after the byte that fills a block");

  a_restart_after_digest: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_o.last_word) |=> (count_q == '0 && hash_q == sha1_pkg::HashInit)
  ) else $error("engine not reinitialized after the last digest word");

  a_word_index_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.word_index <= 3'd4)
  ) else $error("digest word index out of range");

endmodule

`default_nettype wire

>>> hw/rtl/sha1_ram.sv
`default_nettype none

module sha1_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sha1_round.sv
`default_nettype none

module sha1_round (
  input  wire sha1_pkg::sha1_work_t work_i,
  input  wire logic [31:0]          sched_word_i,
  input  wire logic [6:0]           round_i,
  output sha1_pkg::sha1_work_t      work_o
);

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;

  always_comb begin
    if (round_i < 7'd20) begin
      f = work_i.d ^ (work_i.b & (work_i.c ^ work_i.d));
      k = sha1_pkg::RoundK0;
    end else if (round_i < 7'd40) begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = sha1_pkg::RoundK1;
    end else if (round_i < 7'd60) begin
      f = (work_i.b & work_i.c) | (work_i.d & (work_i.b | work_i.c));
      k = sha1_pkg::RoundK2;
    end else begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = sha1_pkg::RoundK3;
    end

    t = {work_i.a[26:0], work_i.a[31:27]} + f + work_i.e + k + sched_word_i;

    work_o.a = t;
    work_o.b = work_i.a;
    work_o.c = {work_i.b[1:0], work_i.b[31:2]};
    work_o.d = work_i.c;
    work_o.e = work_i.d;
  end

endmodule

`default_nettype wire
